// ----- rtl/gwp_pkg.sv -----
package gwp_pkg;

  // Port field widths
  localparam int unsigned WCNT_W  = 7;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned WIDX_W  = 6;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned CELLS_W = 21;

  // Full product width of rows by columns
  localparam int unsigned PROD_W  = 2 * DIM_W;
  // Division steps: one per dividend bit
  localparam int unsigned DIV_STEPS = DIM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_ROWS,
    MODE_CELLS,
    MODE_MIXED
  } mode_e;

  // Classified request, front to back
  typedef struct packed {
    mode_e                mode;
    logic [WCNT_W-1:0]    n;
    logic [DIM_W-1:0]     rows;
    logic [DIM_W-1:0]     cols;
    logic [DIM_W-1:0]     per;     // rows / n
    logic [WCNT_W-1:0]    extra;   // rows mod n
    logic [WCNT_W-1:0]    cells;   // rows * cols, only meaningful in cell mode
  } job_t;

  typedef struct packed {
    logic [WIDX_W-1:0]    worker_index;
    logic [POS_W-1:0]     start_row;
    logic [POS_W-1:0]     start_col;
    logic [CELLS_W-1:0]   cell_count;
    logic                 last_slice;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- rtl/gwp_fifo.sv -----
module gwp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == (AW+1)'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) count_d = count_q + (AW+1)'(1);
    else if (do_rd && !do_wr) count_d = count_q - (AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) slot_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ----- rtl/gwp_front.sv -----
module gwp_front #(
  parameter int unsigned MAX_WORKERS = 64,
  parameter int unsigned MAX_DIM     = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       busy_o,
  input  logic [gwp_pkg::WCNT_W-1:0] worker_count_i,
  input  logic [gwp_pkg::DIM_W-1:0]  board_rows_i,
  input  logic [gwp_pkg::DIM_W-1:0]  board_cols_i,
  output logic                       job_wr_o,
  output gwp_pkg::job_t              job_o,
  input  logic                       job_full_i
);

  localparam int unsigned DIM_CAP = (MAX_DIM > (2**gwp_pkg::DIM_W - 1)) ?
                                    (2**gwp_pkg::DIM_W - 1) : MAX_DIM;
  localparam logic [gwp_pkg::DIM_W-1:0] DIM_HI = gwp_pkg::DIM_W'(DIM_CAP);
  localparam logic [gwp_pkg::DIM_W-1:0] WRK_HI = gwp_pkg::DIM_W'(MAX_WORKERS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_e;

  fstate_e                        state_q;
  logic [gwp_pkg::WCNT_W-1:0]     n_q;
  logic [gwp_pkg::DIM_W-1:0]      rows_q, cols_q;
  logic [gwp_pkg::DIM_W-1:0]      quo_q;    // dividend shifts out, quotient in
  logic [gwp_pkg::WCNT_W:0]       rem_q;
  logic [gwp_pkg::STEP_W-1:0]     step_q;
  logic [gwp_pkg::PROD_W-1:0]     cells_q;

  logic [gwp_pkg::WCNT_W:0]       rem_sh;
  logic                           rem_ge;
  logic [gwp_pkg::DIM_W-1:0]      n_clamped;
  gwp_pkg::mode_e                 mode;

  assign n_clamped = gwp_pkg::clamp_dim(gwp_pkg::DIM_W'(worker_count_i), WRK_HI);

  // Restoring division step
  assign rem_sh = {rem_q[gwp_pkg::WCNT_W-1:0], quo_q[gwp_pkg::DIM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, n_q});

  always_comb begin
    if (rows_q >= gwp_pkg::DIM_W'(n_q)) mode = gwp_pkg::MODE_ROWS;
    else if (gwp_pkg::PROD_W'(n_q) > cells_q) mode = gwp_pkg::MODE_CELLS;
    else mode = gwp_pkg::MODE_MIXED;
  end

  assign busy_o   = (state_q != F_IDLE);
  assign job_wr_o = (state_q == F_PUSH);

  always_comb begin
    job_o       = '0;
    job_o.mode  = mode;
    job_o.n     = n_q;
    job_o.rows  = rows_q;
    job_o.cols  = cols_q;
    job_o.per   = quo_q;
    job_o.extra = rem_q[gwp_pkg::WCNT_W-1:0];
    job_o.cells = cells_q[gwp_pkg::WCNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push_i) begin
            state_q <= F_DIV;
            step_q  <= '0;
          end
        end
        F_DIV: begin
          step_q <= step_q + gwp_pkg::STEP_W'(1);
          if (step_q == gwp_pkg::STEP_W'(gwp_pkg::DIV_STEPS - 1)) state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!job_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      n_q    <= n_clamped[gwp_pkg::WCNT_W-1:0];
      rows_q <= gwp_pkg::clamp_dim(board_rows_i, DIM_HI);
      cols_q <= gwp_pkg::clamp_dim(board_cols_i, DIM_HI);
      quo_q  <= gwp_pkg::clamp_dim(board_rows_i, DIM_HI);
      rem_q  <= '0;
    end else if (state_q == F_DIV) begin
      rem_q <= rem_ge ? rem_sh - {1'b0, n_q} : rem_sh;
      quo_q <= {quo_q[gwp_pkg::DIM_W-2:0], rem_ge};
    end
    cells_q <= gwp_pkg::PROD_W'(rows_q) * gwp_pkg::PROD_W'(cols_q);
  end

endmodule

// ----- rtl/gwp_back.sv -----
module gwp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  gwp_pkg::job_t     job_i,
  output logic              job_rd_o,
  input  logic              res_full_i,
  output logic              res_wr_o,
  output gwp_pkg::result_t  res_o
);

  logic [gwp_pkg::WIDX_W-1:0] idx_q, idx_d;
  logic [gwp_pkg::DIM_W-1:0]  row_q, row_d;
  logic [gwp_pkg::DIM_W-1:0]  col_q, col_d;

  logic                       emit, last;
  logic [gwp_pkg::WCNT_W-1:0] idx_w;
  logic [gwp_pkg::DIM_W:0]    take;
  logic [gwp_pkg::PROD_W:0]   rows_cells;
  logic [gwp_pkg::DIM_W-1:0]  left_rows;
  logic                       col_wrap;

  assign emit     = !job_empty_i && !res_full_i;
  assign idx_w    = {1'b0, idx_q};
  assign last     = (idx_w + gwp_pkg::WCNT_W'(1)) == job_i.n;
  assign job_rd_o = emit && last;
  assign res_wr_o = emit;

  assign take       = {1'b0, job_i.per} +
                      (gwp_pkg::DIM_W+1)'((idx_w < job_i.extra) ? 1'b1 : 1'b0);
  assign rows_cells = (gwp_pkg::PROD_W+1)'(take) * (gwp_pkg::PROD_W+1)'(job_i.cols);
  assign left_rows  = (job_i.rows > row_q) ? job_i.rows - row_q : '0;
  assign col_wrap   = ({1'b0, col_q} + (gwp_pkg::DIM_W+1)'(1)) >= {1'b0, job_i.cols};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    res_o              = '0;
    res_o.worker_index = idx_q;
    res_o.last_slice   = last;
    unique case (job_i.mode)
      gwp_pkg::MODE_ROWS: begin
        res_o.start_row  = row_q[gwp_pkg::POS_W-1:0];
        res_o.cell_count = rows_cells[gwp_pkg::CELLS_W-1:0];
        row_d = row_q + take[gwp_pkg::DIM_W-1:0];
      end
      gwp_pkg::MODE_CELLS: begin
        if (idx_w < job_i.cells) begin
          res_o.start_row  = row_q[gwp_pkg::POS_W-1:0];
          res_o.start_col  = col_q[gwp_pkg::POS_W-1:0];
          res_o.cell_count = gwp_pkg::CELLS_W'(1);
          if (col_wrap) begin
            col_d = '0;
            row_d = row_q + gwp_pkg::DIM_W'(1);
          end else begin
            col_d = col_q + gwp_pkg::DIM_W'(1);
          end
        end
      end
      gwp_pkg::MODE_MIXED: begin
        res_o.start_row = row_q[gwp_pkg::POS_W-1:0];
        res_o.start_col = col_q[gwp_pkg::POS_W-1:0];
        if (gwp_pkg::DIM_W'(job_i.n - idx_w) > left_rows) begin
          res_o.cell_count = gwp_pkg::CELLS_W'(1);
          if (col_wrap) begin
            col_d = '0;
            row_d = row_q + gwp_pkg::DIM_W'(1);
          end else begin
            col_d = col_q + gwp_pkg::DIM_W'(1);
          end
        end else begin
          // finish the partial row or take a whole one
          res_o.cell_count = gwp_pkg::CELLS_W'(job_i.cols - col_q);
          col_d = '0;
          row_d = row_q + gwp_pkg::DIM_W'(1);
        end
      end
      default: begin
        res_o.cell_count = '0;
      end
    endcase
    idx_d = idx_q + gwp_pkg::WIDX_W'(1);
    if (last) begin
      idx_d = '0;
      row_d = '0;
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (emit) begin
      idx_q <= idx_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ----- rtl/grid_work_partitioner_top.sv -----
// Grid work partitioner. Each request word (worker count, board rows, board
// columns; zero reads as one, oversize values saturate to MAX_WORKERS and
// MAX_DIM) yields one result word per worker, in worker order, giving start
// row, start column and cell count of that worker's slice, with last_slice
// set on the final one. Both sides behave as a queue: push/full on the
// request side, empty/pop on the result side. The front end takes a request,
// then runs an 11-step restoring division of rows by workers (one quotient
// bit per cycle) and classifies the request; it is busy (full high) until the
// job is in the job queue. A two-entry job queue then hands the request to
// the back end, which writes one result word per cycle into a two-entry
// result queue while that queue has room. Throughput is set by whichever
// of the two is slower; the front end can take a new request while the
// back end still works through an earlier one. No state carries over from
// one request to the next.
module grid_work_partitioner_top #(
  parameter int unsigned MAX_WORKERS = 64,
  parameter int unsigned MAX_DIM     = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [gwp_pkg::WCNT_W-1:0]  worker_count_i,
  input  logic [gwp_pkg::DIM_W-1:0]   board_rows_i,
  input  logic [gwp_pkg::DIM_W-1:0]   board_cols_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic [gwp_pkg::WIDX_W-1:0]  worker_index_o,
  output logic [gwp_pkg::POS_W-1:0]   start_row_o,
  output logic [gwp_pkg::POS_W-1:0]   start_col_o,
  output logic [gwp_pkg::CELLS_W-1:0] cell_count_o,
  output logic                        last_slice_o
);

  localparam int unsigned JOB_W = $bits(gwp_pkg::job_t);
  localparam int unsigned RES_W = $bits(gwp_pkg::result_t);

  logic             front_busy;
  logic             job_wr, job_full, job_rd, job_empty;
  gwp_pkg::job_t    job_in, job_head;
  logic             res_wr, res_full;
  gwp_pkg::result_t res_in, res_head;

  assign full = front_busy;

  // Front end: clamp, divide, classify
  gwp_front #(
    .MAX_WORKERS(MAX_WORKERS),
    .MAX_DIM    (MAX_DIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .busy_o        (front_busy),
    .worker_count_i(worker_count_i),
    .board_rows_i  (board_rows_i),
    .board_cols_i  (board_cols_i),
    .job_wr_o      (job_wr),
    .job_o         (job_in),
    .job_full_i    (job_full)
  );

  // Job queue decouples front from back
  gwp_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_wr),
    .wr_data_i(job_in),
    .full_o   (job_full),
    .rd_en_i  (job_rd),
    .rd_data_o(job_head),
    .empty_o  (job_empty)
  );

  // Back end: one slice per cycle while the result queue has room, job popped with its last slice
  gwp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_head),
    .job_rd_o   (job_rd),
    .res_full_i (res_full),
    .res_wr_o   (res_wr),
    .res_o      (res_in)
  );

  // Result queue; its slots register the back end's product
  gwp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_wr),
    .wr_data_i(res_in),
    .full_o   (res_full),
    .rd_en_i  (pop),
    .rd_data_o(res_head),
    .empty_o  (empty)
  );

  assign worker_index_o = res_head.worker_index;
  assign start_row_o    = res_head.start_row;
  assign start_col_o    = res_head.start_col;
  assign cell_count_o   = res_head.cell_count;
  assign last_slice_o   = res_head.last_slice;

endmodule

// ----- rtl/gwp_checker.sv -----
module gwp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [gwp_pkg::WIDX_W-1:0]  worker_index_o,
  input logic [gwp_pkg::POS_W-1:0]   start_row_o,
  input logic [gwp_pkg::POS_W-1:0]   start_col_o,
  input logic [gwp_pkg::CELLS_W-1:0] cell_count_o,
  input logic                        last_slice_o
);

  // Slices of one request come out in worker order
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_slice_o) |=>
      (empty || worker_index_o == $past(worker_index_o) + gwp_pkg::WIDX_W'(1)))
    else $error("worker index did not advance by one");

  // A new request starts at worker zero
  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && last_slice_o) |=> (empty || worker_index_o == '0))
    else $error("request did not start at worker zero");

  // Idle workers get an all-zero slice
  a_empty_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && cell_count_o == '0) |-> (start_row_o == '0 && start_col_o == '0))
    else $error("empty slice with non-zero start");

  // Waiting word holds while not popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(worker_index_o) && $stable(cell_count_o)))
    else $error("waiting result word changed");

endmodule

bind grid_work_partitioner_top gwp_checker u_gwp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .worker_index_o(worker_index_o),
  .start_row_o   (start_row_o),
  .start_col_o   (start_col_o),
  .cell_count_o  (cell_count_o),
  .last_slice_o  (last_slice_o)
);

// ----- tb/tb_grid_work_partitioner_top.sv -----
`timescale 1ns / 1ps

module tb_grid_work_partitioner_top;

  localparam int unsigned MAX_WORKERS = 64;
  localparam int unsigned MAX_DIM     = 1024;
  // cycles with no word moving on either side before the run is abandoned;
  // the slowest correct gap adds a driver wait, the front end's division and a pop stall
  localparam int unsigned IDLE_LIMIT  = 3000;
  // quiet time after the last slice, well past the front end's latency
  localparam int unsigned TAIL_CYCLES = 60;

  // one pending request; settle makes the driver wait for every
  // outstanding slice before it offers this word
  typedef struct {
    logic [gwp_pkg::WCNT_W-1:0] workers;
    logic [gwp_pkg::DIM_W-1:0]  rows;
    logic [gwp_pkg::DIM_W-1:0]  cols;
    bit                         settle;
  } request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side, all known from time zero
  logic                       req_push    = 1'b0;
  logic                       full;
  logic [gwp_pkg::WCNT_W-1:0] req_workers = '0;
  logic [gwp_pkg::DIM_W-1:0]  req_rows    = '0;
  logic [gwp_pkg::DIM_W-1:0]  req_cols    = '0;

  // result side
  logic                        empty;
  logic                        res_pop = 1'b0;
  logic [gwp_pkg::WIDX_W-1:0]  worker_index;
  logic [gwp_pkg::POS_W-1:0]   start_row;
  logic [gwp_pkg::POS_W-1:0]   start_col;
  logic [gwp_pkg::CELLS_W-1:0] cell_count;
  logic                        last_slice;

  request_t          requests_todo[$];
  gwp_pkg::result_t  slices_due[$];

  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap    = 0;
  int unsigned send_calm   = 0;
  int unsigned take_gap    = 0;
  int unsigned take_calm   = 0;
  bit          just_sent   = 1'b0;
  // sampled on the falling edge so the driver sees a settled value
  bit          nothing_owed = 1'b1;

  grid_work_partitioner_top #(
    .MAX_WORKERS (MAX_WORKERS),
    .MAX_DIM     (MAX_DIM)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (req_push),
    .full           (full),
    .worker_count_i (req_workers),
    .board_rows_i   (req_rows),
    .board_cols_i   (req_cols),
    .empty          (empty),
    .pop            (res_pop),
    .worker_index_o (worker_index),
    .start_row_o    (start_row),
    .start_col_o    (start_col),
    .cell_count_o   (cell_count),
    .last_slice_o   (last_slice)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Slice predictor
  // ---------------------------------------------------------------------

  function automatic void queue_slice(int unsigned idx, int unsigned n,
                                      int unsigned row, int unsigned col,
                                      int unsigned len);
    gwp_pkg::result_t s;
    s.worker_index = idx[gwp_pkg::WIDX_W-1:0];
    s.start_row    = row[gwp_pkg::POS_W-1:0];
    s.start_col    = col[gwp_pkg::POS_W-1:0];
    s.cell_count   = len[gwp_pkg::CELLS_W-1:0];
    s.last_slice   = (idx + 1 == n);
    slices_due.push_back(s);
  endfunction

  // Works out every slice one request word yields and queues them in
  // worker order.
  function automatic void predict_slices(logic [gwp_pkg::WCNT_W-1:0] wc,
                                         logic [gwp_pkg::DIM_W-1:0]  r_in,
                                         logic [gwp_pkg::DIM_W-1:0]  c_in);
    int unsigned n, rows, cols, cells, row, col, per, extra, take, left;
    gwp_pkg::mode_e mode;
    // zero reads as one, oversize saturates
    n    = (wc == 0) ? 1 : (wc > MAX_WORKERS) ? MAX_WORKERS : wc;
    rows = (r_in == 0) ? 1 : (r_in > MAX_DIM) ? MAX_DIM : r_in;
    cols = (c_in == 0) ? 1 : (c_in > MAX_DIM) ? MAX_DIM : c_in;
    cells = rows * cols;
    per   = rows / n;
    extra = rows % n;
    row   = 0;
    col   = 0;
    if (rows >= n) mode = gwp_pkg::MODE_ROWS;
    else if (n > cells) mode = gwp_pkg::MODE_CELLS;
    else mode = gwp_pkg::MODE_MIXED;

    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        gwp_pkg::MODE_ROWS: begin
          // whole rows; the first (rows mod n) workers take one more
          take = per + ((i < extra) ? 1 : 0);
          queue_slice(i, n, row, 0, take * cols);
          row += take;
        end
        gwp_pkg::MODE_CELLS: begin
          // a cell each, surplus workers idle with an all-zero slice
          if (i < cells) begin
            queue_slice(i, n, row, col, 1);
            if (col + 1 >= cols) begin
              col = 0;
              row++;
            end else begin
              col++;
            end
          end else begin
            queue_slice(i, n, 0, 0, 0);
          end
        end
        default: begin
          // single cells while workers outnumber rows left, then the
          // partial row is finished or a whole row taken
          left = (rows > row) ? rows - row : 0;
          if (n - i > left) begin
            queue_slice(i, n, row, col, 1);
            if (col + 1 >= cols) begin
              col = 0;
              row++;
            end else begin
              col++;
            end
          end else begin
            queue_slice(i, n, row, col, cols - col);
            col = 0;
            row++;
          end
        end
      endcase
    end
  endfunction

  // Random wait before the next word, with the odd run of
  // back-to-back words so both busy and idle phases get exercised.
  function automatic int unsigned draw_wait(ref int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(10, 25);
    return $urandom_range(0, 17);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------

  always @(negedge clk_i) begin
    nothing_owed = (slices_due.size() == 0);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_push    <= 1'b0;
      req_workers <= '0;
      req_rows    <= '0;
      req_cols    <= '0;
      send_gap    = 0;
      just_sent   = 1'b0;
    end else begin
      just_sent = req_push && !full;
      if (just_sent) begin
        predict_slices(req_workers, req_rows, req_cols);
        send_gap = draw_wait(send_calm);
      end

      if (req_push && full) begin
        // word still on offer, hold everything
      end else if (send_gap > 0) begin
        send_gap--;
        req_push <= 1'b0;
      end else if (requests_todo.size() != 0 &&
                   (!requests_todo[0].settle || (nothing_owed && !just_sent))) begin
        req_workers <= requests_todo[0].workers;
        req_rows    <= requests_todo[0].rows;
        req_cols    <= requests_todo[0].cols;
        req_push    <= 1'b1;
        void'(requests_todo.pop_front());
      end else begin
        req_push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pop  <= 1'b0;
      take_gap = 0;
    end else begin
      if (res_pop && !empty) begin
        if (slices_due.size() == 0) begin
          errors++;
          $display({"%0t: unexpected slice, expected none, ",
                    "got worker %0d row %0d col %0d cells %0d last %0d"},
                   $time, worker_index, start_row, start_col, cell_count, last_slice);
        end else begin
          check_field("worker_index", slices_due[0].worker_index, worker_index);
          check_field("start_row",    slices_due[0].start_row,    start_row);
          check_field("start_col",    slices_due[0].start_col,    start_col);
          check_field("cell_count",   slices_due[0].cell_count,   cell_count);
          check_field("last_slice",   slices_due[0].last_slice,   last_slice);
          void'(slices_due.pop_front());
        end
        take_gap = draw_wait(take_calm);
      end

      if (res_pop && empty) begin
        // keep asking
      end else if (take_gap > 0) begin
        take_gap--;
        res_pop <= 1'b0;
      end else begin
        res_pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long without a word moving on either side
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_push && !full) || (res_pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------

  task automatic add_request(int unsigned w, int unsigned r, int unsigned c,
                             bit settle = 1'b0);
    request_t q;
    q.workers = w[gwp_pkg::WCNT_W-1:0];
    q.rows    = r[gwp_pkg::DIM_W-1:0];
    q.cols    = c[gwp_pkg::DIM_W-1:0];
    q.settle  = settle;
    requests_todo.push_back(q);
  endtask

  initial begin : stimulus
    int unsigned n, rows, cols, top, pick;

    // directed words: corners, every mode and the clamping cases
    add_request(1, 1, 1);
    add_request(64, 1024, 1024);              // largest legal board, row mode
    add_request(7, 20, 5);                    // rows mode with remainder
    add_request(16, 16, 3);                   // rows equal workers
    add_request(64, 3, 5, 1'b1);              // cell mode, drained first
    add_request(64, 1, 1);                    // one cell, 63 idle workers
    add_request(12, 3, 4);                    // workers equal cells
    add_request(10, 3, 5);                    // mixed mode
    add_request(64, 63, 1024);                // mixed, one single-cell worker
    add_request(5, 4, 2);
    add_request(10, 5, 1);                    // single column, cell mode
    add_request(0, 0, 0);                     // zeros read as one
    add_request(127, 2047, 2047);             // all ones saturate
    add_request(65, 1025, 1025);              // just over the limits
    add_request(64, 0, 2047);                 // one row, mixed mode
    add_request(1, 1024, 1);
    add_request(2, 1, 1024);
    add_request(64, 64, 1024);
    add_request(33, 1, 33);
    add_request(63, 62, 1);                   // cell mode, 62 cells

    // random words, mostly well-formed for one mode each
    for (int k = 0; k < 250; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n    = $urandom_range(1, MAX_WORKERS);
        top  = ($urandom_range(0, 1) == 1) ?
               ((n + 70 > MAX_DIM) ? MAX_DIM : n + 70) : MAX_DIM;
        rows = $urandom_range(n, top);
        cols = $urandom_range(1, MAX_DIM);
      end else if (pick < 65) begin
        n    = $urandom_range(2, MAX_WORKERS);
        rows = $urandom_range(1, (n - 1 < 8) ? n - 1 : 8);
        cols = $urandom_range(1, (n - 1) / rows);
      end else if (pick < 90) begin
        n    = $urandom_range(2, MAX_WORKERS);
        rows = $urandom_range(1, n - 1);
        top  = (n + rows - 1) / rows;
        cols = $urandom_range(top, ($urandom_range(0, 1) == 1) ? top + 3 : MAX_DIM);
      end else begin
        // raw noise across the whole field widths
        n    = $urandom_range(0, 127);
        rows = $urandom_range(0, 2047);
        cols = $urandom_range(0, 2047);
      end
      add_request(n, rows, cols, $urandom_range(0, 29) == 0);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_todo.size() != 0 || req_push) @(negedge clk_i);
    while (slices_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
